// ----- hdl/pacm_pkg.sv -----
// Package for the point-approach motion controller.
// Holds the fixed-point constants, register and mode codes, the arctangent table
// and the payload types that the cell modules and the top level share.
package pacm_pkg;

  // Parameter defaults and pipeline sizes.
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int DIV_BITS         = 16;

  // Working widths of the two rotator chains and of the divider.
  localparam int VEC_W = 36;
  localparam int ROT_W = 34;
  localparam int ANG_W = 33;
  localparam int REM_W = 35;
  localparam int DEN_W = 18;

  // Rotator gain compensation in Q30, and heading scale to binary angle in Q16.
  localparam logic [29:0]        GAIN_Q30    = 30'd652032874;
  localparam logic signed [35:0] HEAD_TO_BAM = 36'sd10937044409;

  // Bearing error thresholds (0.4 and 0.1 of a half turn in binary angle).
  localparam logic [32:0] ROW2_LIM = 33'd858993459;
  localparam logic [32:0] ROW1_LIM = 33'd214748364;

  // Configuration register indexes.
  localparam logic [1:0] REG_SPEED = 2'd0;
  localparam logic [1:0] REG_LIMIT = 2'd1;
  localparam logic [1:0] REG_MODE  = 2'd2;

  // Approach mode codes.
  localparam logic [1:0] MODE_SIDE_A = 2'd0;
  localparam logic [1:0] MODE_TURN   = 2'd1;
  localparam logic [1:0] MODE_SIDE_B = 2'd2;
  localparam logic [1:0] MODE_NONE   = 2'd3;

  // Forward gain codes.
  localparam logic [1:0] KV_ZERO = 2'd0;
  localparam logic [1:0] KV_HALF = 2'd1;
  localparam logic [1:0] KV_FULL = 2'd2;

  // Data handed along the vectoring chain.
  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic [31:0]             z;
  } vec_t;

  // Data handed along the rotation chain.
  typedef struct packed {
    logic signed [ROT_W-1:0] x;
    logic signed [ROT_W-1:0] y;
    logic signed [ANG_W-1:0] z;
  } rot_t;

  // Data handed along the divider chain.
  typedef struct packed {
    logic [REM_W-1:0]    rem;
    logic [DEN_W-1:0]    den;
    logic [DIV_BITS-1:0] q;
    logic                ov;
    logic                neg;
  } div_t;

  // Arctangent of 2^-i as a 32-bit binary angle.
  function automatic logic [31:0] atan_bam(input int i);
    logic [31:0] r;
    case (i)
      0:  r = 32'h20000000;
      1:  r = 32'h12E4051E;
      2:  r = 32'h09FB385B;
      3:  r = 32'h051111D4;
      4:  r = 32'h028B0D43;
      5:  r = 32'h0145D7E1;
      6:  r = 32'h00A2F61E;
      7:  r = 32'h00517C55;
      8:  r = 32'h0028BE53;
      9:  r = 32'h00145F2F;
      10: r = 32'h000A2F98;
      11: r = 32'h000517CC;
      12: r = 32'h00028BE6;
      13: r = 32'h000145F3;
      14: r = 32'h0000A2FA;
      15: r = 32'h0000517D;
      16: r = 32'h000028BE;
      17: r = 32'h0000145F;
      18: r = 32'h00000A30;
      19: r = 32'h00000518;
      20: r = 32'h0000028C;
      21: r = 32'h00000146;
      22: r = 32'h000000A3;
      23: r = 32'h00000051;
      24: r = 32'h00000029;
      25: r = 32'h00000014;
      26: r = 32'h0000000A;
      27: r = 32'h00000005;
      28: r = 32'h00000003;
      29: r = 32'h00000001;
      30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

// ----- hdl/point_approach_motion_controller_unit.sv -----
// Top level of the point-approach motion controller.
// Depends on pacm_pkg, pacm_vec_cell, pacm_rot_cell, pacm_div_cell and pacm_delay.
//
// The block takes one item in every clock cycle (busy stays low) and delivers its
// results in order, with done high for a single cycle for each; results cannot be
// held off, so the receiver must take each one as it appears. The path runs
// through the two rotator chains of CORDIC_STEPS cells each, the sixteen-cell
// divider chain for the turn command and seven staging registers. The user must write
// configuration through the APB port only while no item is in flight; the block does not enforce it.
module point_approach_motion_controller_unit
  import pacm_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] target_x,
  input  logic signed [31:0] target_y,
  input  logic signed [31:0] robot_x,
  input  logic signed [31:0] robot_y,
  input  logic signed [15:0] robot_heading,
  input  logic signed [15:0] turn_rate,
  output logic               done,
  output logic signed [15:0] forward_speed,
  output logic signed [15:0] left_speed,
  output logic signed [15:0] turn_speed,
  output logic [31:0]        target_distance,
  output logic               command_valid,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int LAT = 2*CORDIC_STEPS + DIV_BITS + 7;

  typedef struct packed {
    logic [31:0]        hb;
    logic               zero;
    logic signed [15:0] tr;
  } ctx_a_t;

  typedef struct packed {
    logic [31:0]        tdist;
    logic               zero;
    logic signed [53:0] prod;
    logic signed [19:0] kdtr;
    logic [1:0]         kv;
  } ctx_b_t;

  typedef struct packed {
    logic signed [15:0] fwd;
    logic signed [15:0] left;
    logic [31:0]        tdist;
    logic               zero;
    logic [1:0]         kv;
  } ctx_c_t;

  // Configuration registers and APB port.
  logic [14:0] speed_setting;
  logic [14:0] turn_limit;
  logic [1:0]  approach_mode;
  logic [14:0] wv;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign wv     = (turn_limit == '0) ? 15'd1 : turn_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_setting <= '0;
      turn_limit    <= 15'd4096;
      approach_mode <= MODE_SIDE_A;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_SPEED: speed_setting <= pwdata[14:0];
        REG_LIMIT: turn_limit    <= pwdata[14:0];
        REG_MODE:  approach_mode <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_SPEED: prdata = {17'd0, speed_setting};
      REG_LIMIT: prdata = {17'd0, turn_limit};
      REG_MODE:  prdata = {30'd0, approach_mode};
      default:   prdata = '0;
    endcase
  end

  // Valid marks travel down a shift register beside the data.
  logic [LAT-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], start && !busy};
    end
  end

  // Input capture.
  logic signed [31:0] in_tx, in_ty, in_rx, in_ry;
  logic signed [15:0] in_hd, in_tr;

  always_ff @(posedge clk) begin
    in_tx <= target_x;
    in_ty <= target_y;
    in_rx <= robot_x;
    in_ry <= robot_y;
    in_hd <= robot_heading;
    in_tr <= turn_rate;
  end

  // Differences, heading conversion and vectoring set-up.
  logic signed [32:0] dx_s, dy_s;
  logic signed [51:0] hbp;
  vec_t   vin_next, vin;
  ctx_a_t ca_next, ca_in, ca;

  always_comb begin
    dx_s = $signed({in_tx[31], in_tx}) - $signed({in_rx[31], in_rx});
    dy_s = $signed({in_ty[31], in_ty}) - $signed({in_ry[31], in_ry});
    hbp  = 52'(in_hd) * 52'(HEAD_TO_BAM) + 52'sd32768;
    if (dx_s[32]) begin
      vin_next.x = -VEC_W'(dx_s);
      vin_next.y = -VEC_W'(dy_s);
      vin_next.z = 32'h80000000;
    end else begin
      vin_next.x = VEC_W'(dx_s);
      vin_next.y = VEC_W'(dy_s);
      vin_next.z = '0;
    end
    ca_next.hb   = hbp[47:16];
    ca_next.zero = (dx_s == '0) && (dy_s == '0);
    ca_next.tr   = in_tr;
  end

  always_ff @(posedge clk) begin
    vin   <= vin_next;
    ca_in <= ca_next;
  end

  // Vectoring chain: bearing and range to the target.
  vec_t vchain [CORDIC_STEPS+1];
  assign vchain[0] = vin;

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_vec
    pacm_vec_cell #(.STEP(g)) u_cell (
      .clk  (clk),
      .din  (vchain[g]),
      .dout (vchain[g+1])
    );
  end

  pacm_delay #(.W($bits(ctx_a_t)), .DEPTH(CORDIC_STEPS)) u_dly_a (
    .clk  (clk),
    .din  (ca_in),
    .dout (ca)
  );

  // Range partial products, bearing error and gain selection.
  logic signed [VEC_W-1:0] vx;
  logic [34:0]             xc;
  logic [31:0]             phi, esr, ang_next;
  logic signed [32:0]      es, ae;
  logic [16:0]             atr;
  logic [1:0]              row, col, kv_next;
  logic [4:0]              kp10;
  logic [2:0]              kd10;
  logic [47:0]             pl_next;
  logic [46:0]             ph_next;
  logic signed [37:0]      kpes_next;
  logic signed [19:0]      kdtr_next;

  always_comb begin
    vx  = vchain[CORDIC_STEPS].x;
    xc  = vx[VEC_W-1] ? '0 : vx[34:0];
    pl_next = xc[17:0] * GAIN_Q30;
    ph_next = xc[34:18] * GAIN_Q30;
    phi = ca.zero ? '0 : vchain[CORDIC_STEPS].z;
    esr = phi - ca.hb;
    ang_next = ca.hb - phi;
    // A half-turn error counts as positive.
    es  = (esr == 32'h80000000) ? 33'sh80000000 : 33'($signed(esr));
    ae  = es[32] ? -es : es;
    atr = ca.tr[15] ? 17'(-$signed({ca.tr[15], ca.tr})) : 17'(ca.tr);
    if (ae > $signed(ROW2_LIM)) begin
      row = 2'd2;
    end else if (ae > $signed(ROW1_LIM)) begin
      row = 2'd1;
    end else begin
      row = 2'd0;
    end
    if ({atr, 1'b0} > 18'(wv)) begin
      col = 2'd2;
    end else if (21'(atr) * 21'd10 > 21'(wv)) begin
      col = 2'd1;
    end else begin
      col = 2'd0;
    end
    case (row)
      2'd0: begin
        kv_next = KV_FULL;
        kd10    = 3'd5;
        kp10    = 5'd30;
      end
      2'd1: begin
        kv_next = KV_HALF;
        kd10    = 3'd2;
        case (col)
          2'd0:    kp10 = 5'd20;
          2'd1:    kp10 = 5'd10;
          default: kp10 = 5'd0;
        endcase
      end
      default: begin
        kv_next = KV_ZERO;
        kd10    = 3'd0;
        kp10    = 5'd10;
      end
    endcase
    kpes_next = es * $signed({1'b0, kp10});
    kdtr_next = ca.tr * $signed({1'b0, kd10});
  end

  logic [47:0]        m_pl;
  logic [46:0]        m_ph;
  logic               m_zero;
  logic [31:0]        m_ang;
  logic signed [37:0] m_kpes;
  logic signed [19:0] m_kdtr;
  logic [1:0]         m_kv;

  always_ff @(posedge clk) begin
    m_pl   <= pl_next;
    m_ph   <= ph_next;
    m_zero <= ca.zero;
    m_ang  <= ang_next;
    m_kpes <= kpes_next;
    m_kdtr <= kdtr_next;
    m_kv   <= kv_next;
  end

  // Range rounding, rotation set-up and the proportional product.
  logic [65:0]             msum;
  logic [35:0]             m36;
  logic signed [ANG_W-1:0] zs;
  logic signed [ROT_W-1:0] x0;
  rot_t   rin_next, rin;
  ctx_b_t cb_next, cb_in, cb;

  always_comb begin
    msum = {1'b0, m_ph, 18'd0} + 66'(m_pl) + 66'd536870912;
    m36  = msum[65:30];
    cb_next.tdist = m_zero ? '0 : ((m36[35:32] != '0) ? 32'hFFFFFFFF : m36[31:0]);
    cb_next.zero = m_zero;
    cb_next.prod = m_kpes * $signed({1'b0, wv});
    cb_next.kdtr = m_kdtr;
    cb_next.kv   = m_kv;
    x0 = $signed({3'd0, speed_setting, 16'd0});
    zs = 33'($signed(m_ang));
    // Fold angles beyond a quarter turn back into range.
    if (zs > 33'sd1073741824) begin
      rin_next.z = zs - 33'sd2147483648;
      rin_next.x = -x0;
    end else if (zs < -33'sd1073741824) begin
      rin_next.z = zs + 33'sd2147483648;
      rin_next.x = -x0;
    end else begin
      rin_next.z = zs;
      rin_next.x = x0;
    end
    rin_next.y = '0;
  end

  always_ff @(posedge clk) begin
    rin   <= rin_next;
    cb_in <= cb_next;
  end

  // Rotation chain: speed resolved along the bearing in the robot frame.
  rot_t rchain [CORDIC_STEPS+1];
  assign rchain[0] = rin;

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_rot
    pacm_rot_cell #(.STEP(g)) u_cell (
      .clk  (clk),
      .din  (rchain[g]),
      .dout (rchain[g+1])
    );
  end

  pacm_delay #(.W($bits(ctx_b_t)), .DEPTH(CORDIC_STEPS)) u_dly_b (
    .clk  (clk),
    .din  (cb_in),
    .dout (cb)
  );

  // Gain partial products of the rotated vector and the turn numerator.
  logic signed [47:0] pxh_next, pyh_next;
  logic [46:0]        pxl_next, pyl_next;
  logic signed [55:0] num;
  logic [54:0]        mag_next;
  rot_t               ro;

  always_comb begin
    ro       = rchain[CORDIC_STEPS];
    pxh_next = $signed(ro.x[33:17]) * $signed({1'b0, GAIN_Q30});
    pyh_next = $signed(ro.y[33:17]) * $signed({1'b0, GAIN_Q30});
    pxl_next = ro.x[16:0] * GAIN_Q30;
    pyl_next = ro.y[16:0] * GAIN_Q30;
    num      = -(56'(cb.prod) + (56'(cb.kdtr) <<< 31));
    mag_next = num[55] ? 55'(-num) : 55'(num);
  end

  logic signed [47:0] r_pxh, r_pyh;
  logic [46:0]        r_pxl, r_pyl;
  logic [54:0]        r_mag;
  logic               r_neg;
  logic [31:0]        r_dist;
  logic               r_zero;
  logic [1:0]         r_kv;

  always_ff @(posedge clk) begin
    r_pxh  <= pxh_next;
    r_pyh  <= pyh_next;
    r_pxl  <= pxl_next;
    r_pyl  <= pyl_next;
    r_mag  <= mag_next;
    r_neg  <= num[55];
    r_dist <= cb.tdist;
    r_zero <= cb.zero;
    r_kv   <= cb.kv;
  end

  // Rounded sideways commands and divider set-up.
  logic signed [65:0] csum, ssum;
  logic signed [19:0] c20, s20;
  logic [55:0]        nsum;
  logic [DEN_W-1:0]   den;
  div_t   din_next, dv_in;
  ctx_c_t cc_next, cc_in, cc;

  function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
    logic signed [15:0] r;
    if (v > 20'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -20'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  always_comb begin
    csum = (66'(r_pxh) <<< 17) + $signed({19'd0, r_pxl}) + 66'sh200000000000;
    ssum = (66'(r_pyh) <<< 17) + $signed({19'd0, r_pyl}) + 66'sh200000000000;
    c20  = csum[65:46];
    s20  = ssum[65:46];
    den  = 18'(wv) * 18'd5;
    nsum = 56'(r_mag) + (56'(den) << 19);
    din_next.rem = nsum[54:20];
    din_next.den = den;
    din_next.q   = '0;
    din_next.ov  = nsum[54:20] >= (REM_W'(den) << DIV_BITS);
    din_next.neg = r_neg;
    cc_next.fwd  = sat16(c20);
    cc_next.left = sat16(s20);
    cc_next.tdist = r_dist;
    cc_next.zero = r_zero;
    cc_next.kv   = r_kv;
  end

  always_ff @(posedge clk) begin
    dv_in <= din_next;
    cc_in <= cc_next;
  end

  // Divider chain, most significant quotient bit first.
  div_t dchain [DIV_BITS+1];
  assign dchain[0] = dv_in;

  for (genvar g = 0; g < DIV_BITS; g++) begin : g_div
    pacm_div_cell #(.SHIFT(DIV_BITS-1-g)) u_cell (
      .clk  (clk),
      .din  (dchain[g]),
      .dout (dchain[g+1])
    );
  end

  pacm_delay #(.W($bits(ctx_c_t)), .DEPTH(DIV_BITS)) u_dly_c (
    .clk  (clk),
    .din  (cc_in),
    .dout (cc)
  );

  // Mode selection and result register.
  div_t               dq;
  logic [15:0]        qm;
  logic signed [15:0] turn_c, fwd_c, fwd_o, left_o, turn_o;
  logic               valid_o;

  always_comb begin
    dq = dchain[DIV_BITS];
    if (dq.ov || dq.q > 16'(wv)) begin
      qm = 16'(wv);
    end else begin
      qm = dq.q;
    end
    turn_c = dq.neg ? -$signed(qm) : $signed(qm);
    case (cc.kv)
      KV_FULL: fwd_c = $signed({1'b0, speed_setting});
      KV_HALF: fwd_c = $signed(16'((16'(speed_setting) + 16'd1) >> 1));
      default: fwd_c = '0;
    endcase
    case (approach_mode)
      MODE_SIDE_A, MODE_SIDE_B: begin
        fwd_o   = cc.zero ? '0 : cc.fwd;
        left_o  = cc.zero ? '0 : cc.left;
        turn_o  = '0;
        valid_o = 1'b1;
      end
      MODE_TURN: begin
        fwd_o   = fwd_c;
        left_o  = '0;
        turn_o  = turn_c;
        valid_o = 1'b1;
      end
      default: begin
        fwd_o   = '0;
        left_o  = '0;
        turn_o  = '0;
        valid_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    forward_speed   <= fwd_o;
    left_speed      <= left_o;
    turn_speed      <= turn_o;
    target_distance <= cc.tdist;
    command_valid   <= valid_o;
  end

  assign done = vld[LAT-1];

endmodule

// ----- hdl/pacm_vec_cell.sv -----
// One vectoring step of the rotator that finds bearing and range.
// Depends on pacm_pkg for vec_t and the arctangent table.
module pacm_vec_cell
  import pacm_pkg::*;
#(
  parameter int STEP = 0
) (
  input  logic clk,
  input  vec_t din,
  output vec_t dout
);

  logic signed [VEC_W-1:0] xi, yi, sx, sy;
  vec_t nxt;

  // Drive y towards zero and accumulate the angle turned.
  always_comb begin
    xi = din.x;
    yi = din.y;
    sx = xi >>> STEP;
    sy = yi >>> STEP;
    if (!yi[VEC_W-1]) begin
      nxt.x = xi + sy;
      nxt.y = yi - sx;
      nxt.z = din.z + atan_bam(STEP);
    end else begin
      nxt.x = xi - sy;
      nxt.y = yi + sx;
      nxt.z = din.z - atan_bam(STEP);
    end
  end

  always_ff @(posedge clk) begin
    dout <= nxt;
  end

endmodule

// ----- hdl/pacm_rot_cell.sv -----
// One rotation step of the rotator that resolves speed into the robot frame.
// Depends on pacm_pkg for rot_t and the arctangent table.
module pacm_rot_cell
  import pacm_pkg::*;
#(
  parameter int STEP = 0
) (
  input  logic clk,
  input  rot_t din,
  output rot_t dout
);

  logic signed [ROT_W-1:0] xi, yi, sx, sy;
  logic signed [ANG_W-1:0] zi, at;
  rot_t nxt;

  // Drive the residual angle towards zero.
  always_comb begin
    xi = din.x;
    yi = din.y;
    zi = din.z;
    at = $signed({1'b0, atan_bam(STEP)});
    sx = xi >>> STEP;
    sy = yi >>> STEP;
    if (!zi[ANG_W-1]) begin
      nxt.x = xi - sy;
      nxt.y = yi + sx;
      nxt.z = zi - at;
    end else begin
      nxt.x = xi + sy;
      nxt.y = yi - sx;
      nxt.z = zi + at;
    end
  end

  always_ff @(posedge clk) begin
    dout <= nxt;
  end

endmodule

// ----- hdl/pacm_div_cell.sv -----
// One restoring-division step: settles one quotient bit of the turn command.
// Depends on pacm_pkg for div_t.
module pacm_div_cell
  import pacm_pkg::*;
#(
  parameter int SHIFT = 0
) (
  input  logic clk,
  input  div_t din,
  output div_t dout
);

  logic [REM_W-1:0] dd;
  div_t nxt;

  // Subtract the shifted divisor where it fits.
  always_comb begin
    dd  = REM_W'(din.den) << SHIFT;
    nxt = din;
    if (din.rem >= dd) begin
      nxt.rem      = din.rem - dd;
      nxt.q[SHIFT] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    dout <= nxt;
  end

endmodule

// ----- hdl/pacm_delay.sv -----
// Shift line that carries side data of an item alongside a chain of cells.
// Stand-alone; no package needed.
module pacm_delay #(
  parameter int W     = 8,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  logic [W-1:0] line [DEPTH];

  // Advance every tap once per cycle.
  always_ff @(posedge clk) begin
    line[0] <= din;
    for (int i = 1; i < DEPTH; i++) begin
      line[i] <= line[i-1];
    end
  end

  assign dout = line[DEPTH-1];

endmodule

// ----- hdl/pacm_checker.sv -----
// Port-level checks for the point-approach motion controller.
// Depends on pacm_pkg; bound to the top level at the end of this file.
module pacm_port_props
  import pacm_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input logic signed [15:0] forward_speed,
  input logic signed [15:0] left_speed,
  input logic signed [15:0] turn_speed,
  input logic               command_valid
);

  localparam int LAT = 2*CORDIC_STEPS + DIV_BITS + 7;

  // Every result belongs to an item taken earlier.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LAT))
    else $error("result without a matching item");

  // The block keeps accepting items.
  a_accept: assert property (@(posedge clk) disable iff (rst)
    !busy)
    else $error("busy raised");

  // A result with no command carries zero speeds.
  a_no_cmd: assert property (@(posedge clk) disable iff (rst)
    (done && !command_valid) |->
      (forward_speed == '0 && left_speed == '0 && turn_speed == '0))
    else $error("speeds set without a command");

  // Sideways and turning commands never mix.
  a_exclusive: assert property (@(posedge clk) disable iff (rst)
    (done && left_speed != '0) |-> (turn_speed == '0))
    else $error("sideways and turn command together");

endmodule

bind point_approach_motion_controller_unit pacm_port_props #(
  .CORDIC_STEPS(CORDIC_STEPS)
) u_pacm_port_props (.*);

// ----- tb/sv/pacm_checker.sv -----
// Result checker for the point-approach motion controller.
// Watches the item, result and register channels, predicts each result and compares it.
// Depends on pacm_pkg for the register and mode codes and the fixed-point constants.
module pacm_checker
  import pacm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic signed [31:0] target_x,
  input  logic signed [31:0] target_y,
  input  logic signed [31:0] robot_x,
  input  logic signed [31:0] robot_y,
  input  logic signed [15:0] robot_heading,
  input  logic signed [15:0] turn_rate,
  input  logic               done,
  input  logic signed [15:0] forward_speed,
  input  logic signed [15:0] left_speed,
  input  logic signed [15:0] turn_speed,
  input  logic [31:0]        target_distance,
  input  logic               command_valid,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint GAIN = GAIN_Q30;
  localparam longint HEAD_SCALE = HEAD_TO_BAM;
  localparam int STEPS = 16;

  typedef struct {
    logic [15:0] fwd;
    logic [15:0] left;
    logic [15:0] turn;
    logic [31:0] tdist;
    logic        valid;
  } command_t;

  // Arctangent of 2^-i as a binary angle, one entry per rotation step.
  localparam logic [31:0] ARCTAN [STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
  };

  command_t    awaited_cmds[$];
  logic [14:0] speed_reg;
  logic [14:0] limit_reg;
  logic [1:0]  mode_reg;

  // Bearing and range of the offset vector.
  function automatic void polar_of(input longint xi, input longint yi,
                                   output logic [31:0] ang, output logic [31:0] mag);
    longint x, y, sx, sy;
    logic [31:0] z;
    longint unsigned m;
    x = xi;
    y = yi;
    z = 32'h0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32'h80000000;
    end
    for (int i = 0; i < STEPS; i++) begin
      sx = x >>> i;
      sy = y >>> i;
      if (y >= 0) begin
        x += sy; y -= sx; z += ARCTAN[i];
      end else begin
        x -= sy; y += sx; z -= ARCTAN[i];
      end
    end
    if (x < 0) x = 0;
    m = (longint'(unsigned'(x)) * 64'd652032874 + (64'd1 << 29)) >> 30;
    ang = z;
    mag = (m > 64'hFFFFFFFF) ? 32'hFFFFFFFF : m[31:0];
  endfunction

  // Speed times cosine and sine of a binary angle, rounded to nearest.
  function automatic void resolve_speed(input longint v, input logic [31:0] a,
                                        output longint c, output longint s);
    longint x, y, z, sx, sy;
    x = v * 65536;
    y = 0;
    z = longint'($signed(a));
    if (z > 64'sh40000000) begin
      z -= 64'sh80000000; x = -x;
    end else if (z < -64'sh40000000) begin
      z += 64'sh80000000; x = -x;
    end
    for (int i = 0; i < STEPS; i++) begin
      sx = x >>> i;
      sy = y >>> i;
      if (z >= 0) begin
        x -= sy; y += sx; z -= longint'(ARCTAN[i]);
      end else begin
        x += sy; y -= sx; z += longint'(ARCTAN[i]);
      end
    end
    c = (x * GAIN + (64'sd1 <<< 45)) >>> 46;
    s = (y * GAIN + (64'sd1 <<< 45)) >>> 46;
  endfunction

  function automatic longint clip16(input longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Expected command for one item under the current register settings.
  function automatic command_t predict_command(input longint dx, input longint dy,
                                               input longint hd, input longint tr);
    command_t r;
    logic [31:0] phi, hb, rng, err;
    longint v, fwd, left, turn, w, es, ae, atr, num, den, mag, q, kp10, kd10, kv;
    logic zero_range;
    int row, col;
    phi = 0;
    rng = 0;
    fwd = 0;
    left = 0;
    turn = 0;
    v = speed_reg;
    zero_range = (dx == 0) && (dy == 0);
    r.valid = 1'b0;
    if (!zero_range) polar_of(dx, dy, phi, rng);
    hb = 32'((hd * HEAD_SCALE + 32768) >>> 16);
    if (mode_reg == MODE_SIDE_A || mode_reg == MODE_SIDE_B) begin
      r.valid = 1'b1;
      if (!zero_range) begin
        resolve_speed(v, hb - phi, fwd, left);
        fwd = clip16(fwd);
        left = clip16(left);
      end
    end else if (mode_reg == MODE_TURN) begin
      w = (limit_reg != 0) ? longint'(limit_reg) : 1;
      err = phi - hb;
      es = longint'($signed(err));
      // A bearing error of exactly a half turn counts as positive.
      if (es == -64'sd2147483648) es = 64'sd2147483648;
      ae = (es < 0) ? -es : es;
      atr = (tr < 0) ? -tr : tr;
      row = (ae > longint'(ROW2_LIM)) ? 2 : ((ae > longint'(ROW1_LIM)) ? 1 : 0);
      col = (2 * atr > w) ? 2 : ((10 * atr > w) ? 1 : 0);
      if (row == 0) begin
        kv = 2; kd10 = 5; kp10 = 30;
      end else if (row == 1) begin
        kv = 1; kd10 = 2; kp10 = (col == 0) ? 20 : ((col == 1) ? 10 : 0);
      end else begin
        kv = 0; kd10 = 0; kp10 = 10;
      end
      num = -(kp10 * es * w + kd10 * tr * 64'sd2147483648);
      den = 10 * w * 524288;
      mag = (num < 0) ? -num : num;
      q = (mag + den / 2) / den;
      turn = (num < 0) ? -q : q;
      if (turn > w) turn = w;
      if (turn < -w) turn = -w;
      fwd = (kv == 2) ? v : ((kv == 1) ? (v + 1) / 2 : 0);
      r.valid = 1'b1;
    end
    r.fwd = fwd[15:0];
    r.left = left[15:0];
    r.turn = turn[15:0];
    r.tdist = rng;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
  end

  // Sampled at the rising edge, before the block's own outputs move.
  always @(posedge clk) begin
    command_t want;
    if (rst) begin
      speed_reg <= 15'd0;
      limit_reg <= 15'd4096;
      mode_reg  <= MODE_SIDE_A;
      awaited_cmds.delete();
    end else begin
      if (done) begin
        if (awaited_cmds.size() == 0) begin
          report_mismatch("unexpected result", 32'h0, 32'h0);
        end else begin
          want = awaited_cmds.pop_front();
          if (forward_speed !== want.fwd) report_mismatch("forward_speed", forward_speed, want.fwd);
          if (left_speed !== want.left) report_mismatch("left_speed", left_speed, want.left);
          if (turn_speed !== want.turn) report_mismatch("turn_speed", turn_speed, want.turn);
          if (target_distance !== want.tdist)
            report_mismatch("target_distance", target_distance, want.tdist);
          if (command_valid !== want.valid)
            report_mismatch("command_valid", command_valid, want.valid);
        end
      end
      if (start && !busy) begin
        awaited_cmds.push_back(predict_command(
            longint'(target_x) - longint'(robot_x), longint'(target_y) - longint'(robot_y),
            longint'(robot_heading), longint'(turn_rate)));
      end
      // Register writes; an address past the last register is ignored.
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_SPEED: speed_reg <= pwdata[14:0];
          REG_LIMIT: limit_reg <= pwdata[14:0];
          REG_MODE:  mode_reg  <= pwdata[1:0];
          default: ;
        endcase
      end
    end
    pending = awaited_cmds.size();
  end

  final begin
    if (awaited_cmds.size() != 0)
      $display("%0d results never arrived", awaited_cmds.size());
  end
endmodule

// ----- tb/sv/tb_top.sv -----
// Top of the point-approach motion controller testbench.
// Drives items and register writes into the block and gives the verdict from pacm_checker.
// Depends on pacm_pkg, pacm_checker and point_approach_motion_controller_unit.
module tb_top;
  import pacm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES = 2 * CORDIC_STEPS_DEF + 30;
  localparam int PHASE_ITEMS = 240;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic signed [31:0] target_x = '0;
  logic signed [31:0] target_y = '0;
  logic signed [31:0] robot_x = '0;
  logic signed [31:0] robot_y = '0;
  logic signed [15:0] robot_heading = '0;
  logic signed [15:0] turn_rate = '0;
  logic               done;
  logic signed [15:0] forward_speed;
  logic signed [15:0] left_speed;
  logic signed [15:0] turn_speed;
  logic [31:0]        target_distance;
  logic               command_valid;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [3:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  int                 fail_count;
  int                 pending;
  int                 idle_pct;

  point_approach_motion_controller_unit DUT (.*);

  pacm_checker u_checker (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Offer one item, hold it until taken, then idle at random.
  task automatic send_item(input logic [31:0] tx, input logic [31:0] ty,
                           input logic [31:0] rx, input logic [31:0] ry,
                           input logic [15:0] hd, input logic [15:0] tr);
    @(negedge clk);
    target_x = tx;
    target_y = ty;
    robot_x = rx;
    robot_y = ry;
    robot_heading = hd;
    turn_rate = tr;
    start = 1'b1;
    do @(posedge clk); while (busy);
    while ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk);
      start = 1'b0;
      @(posedge clk);
    end
  endtask

  // Random item: mostly the robot near the target, sometimes anywhere.
  task automatic send_random_item();
    logic [31:0] rx, ry, dx, dy;
    logic [15:0] tr;
    int sel;
    rx = $urandom();
    ry = $urandom();
    sel = $urandom_range(0, 9);
    if (sel < 2) begin
      dx = $urandom();
      dy = $urandom();
    end else if (sel < 6) begin
      dx = $signed($urandom()) >>> $urandom_range(10, 31);
      dy = $signed($urandom()) >>> $urandom_range(10, 31);
    end else begin
      dx = $signed($urandom()) >>> $urandom_range(0, 12);
      dy = $signed($urandom()) >>> $urandom_range(0, 12);
    end
    tr = $signed(16'($urandom())) >>> $urandom_range(0, 15);
    send_item(rx + dx, ry + dy, rx, ry, 16'($urandom()), tr);
  endtask

  // Stop offering and let every outstanding result come out.
  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic configure(input logic [31:0] speed, input logic [31:0] limit,
                           input logic [31:0] mode);
    drain();
    write_reg(REG_SPEED, speed);
    write_reg(REG_LIMIT, limit);
    write_reg(REG_MODE, mode);
  endtask

  task automatic send_directed();
    send_item(32'h0, 32'h0, 32'h0, 32'h0, 16'h0, 16'h0);
    send_item(32'h1234_5678, 32'h0BAD_F00D, 32'h1234_5678, 32'h0BAD_F00D, 16'h7FFF, 16'h8000);
    send_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 16'h8000, 16'h7FFF);
    send_item(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h7FFF, 16'h8000);
    send_item(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 16'h0, 16'h0);
    send_item(32'hFFFF_0000, 32'h0, 32'h0, 32'h0, 16'h0, 16'h1000);
    send_item(32'hFFFF_0000, 32'h0, 32'h0, 32'h0, 16'h6488, 16'hF000);
    send_item(32'hFFFF_0000, 32'h0, 32'h0, 32'h0, 16'h9B78, 16'h0199);
    send_item(32'h0001_0000, 32'h0, 32'h0, 32'h0, 16'h0, 16'h0);
    send_item(32'h0, 32'h0001_0000, 32'h0, 32'h0, 16'h3244, 16'h0666);
    send_item(32'h0, 32'hFFFF_0000, 32'h0, 32'h0, 16'h3244, 16'hF99A);
    send_item(32'h0000_0001, 32'h0000_0001, 32'h0, 32'h0, 16'h1922, 16'h0800);
    send_item(32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 16'h8000, 16'h7FFF);
    send_item(32'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
  endtask

  // Register settings and item phases, with the sender's idling rate per phase.
  initial begin
    logic [31:0] mixed_speed, mixed_limit;
    idle_pct = 7;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    configure(4096, 4096, MODE_SIDE_A);
    send_directed();
    configure(32767, 32767, MODE_TURN);
    send_directed();
    for (int phase = 0; phase < 8; phase++) begin
      idle_pct = (phase < 3) ? 7 : ((phase < 6) ? 71 : 0);
      mixed_speed = $urandom_range(0, 32767);
      mixed_limit = $urandom_range(1, 32767);
      case (phase)
        0: configure(4096, 4096, MODE_SIDE_A);
        1: configure(32767, 32767, MODE_TURN);
        2: configure(0, 1, MODE_TURN);
        3: configure(12345, 2048, MODE_SIDE_B);
        4: configure(mixed_speed, mixed_limit, MODE_TURN);
        5: configure(32767, 0, MODE_TURN);
        6: begin
          configure(20000, 1000, MODE_NONE);
          // The unused fourth slot must leave every register alone.
          write_reg(2'd3, 32'hFFFF_FFFF);
        end
        default: configure(mixed_speed, mixed_limit, $urandom_range(0, 3));
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 4 && n == PHASE_ITEMS / 2) begin
          @(negedge clk);
          start = 1'b0;
          wait (pending == 0);
        end
        send_random_item();
      end
    end
    drain();
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end
endmodule

// ----- files.f -----
hdl/pacm_pkg.sv
hdl/pacm_vec_cell.sv
hdl/pacm_rot_cell.sv
hdl/pacm_div_cell.sv
hdl/pacm_delay.sv
hdl/point_approach_motion_controller_unit.sv
hdl/pacm_checker.sv
tb/sv/pacm_checker.sv
tb/sv/tb_top.sv
